// File: rtl/spns_pkg.sv
// shared types and constants for the strict priority scheduler
`timescale 1ns / 1ps
package spns_pkg;

  localparam int LEVELS   = 4;
  localparam int LVL_W    = 2;
  localparam int ID_W     = 8;
  localparam int PRIO_W   = 3;
  localparam int LEN_W    = 12;
  localparam int TIME_W   = 16;

  localparam logic [TIME_W-1:0] CUTOFF_RESET = 16'd100;
  localparam logic [TIME_W-1:0] TIME_MAX     = 16'hFFFF;

  // word kinds on the input channel
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  // outcome of the level search
  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] lvl;
  } pick_t;

endpackage

// File: rtl/spns_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module spns_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/spns_pick.sv
// fixed priority search over the non-empty levels, lowest index wins
`timescale 1ns / 1ps
module spns_pick (
  input  logic [spns_pkg::LEVELS-1:0] nonempty,
  output spns_pkg::pick_t             pick
);
  import spns_pkg::*;

  always_comb begin
    pick = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pick.found = 1'b1;
        pick.lvl   = LVL_W'(i);
      end
    end
  end

endmodule

// File: rtl/strict_priority_nonpreemptive_scheduler_unit.sv
// top level of the four level strict priority non-preemptive scheduler
`timescale 1ns / 1ps
// Usage:
//   input channel (in_valid / in_stall) carries one word per job arrival
//   (in_kind = 0, with id, priority 1..4 and run length) or per time tick
//   (in_kind = 1). every input word gives exactly one result word on the
//   out channel (out_valid / out_stall), in order.
//   cfg_we / cfg_wdata set the start cutoff; write it only while idle.
// Timing:
//   a result word passes the input register, the decision register and the
//   output register in turn. one word per clock is sustained while out_stall
//   is low: the level search and queue bookkeeping sit in the one decision
//   stage, and the queue ram read is bypassed into the decision and output stages.
// Reset (rst_n low, synchronous):
//   queues empty, no job running, time 0, cutoff 100, pipeline empty.
//   queue storage is not cleared; only written slots are ever read.
// Stall:
//   out_stall with out_valid high freezes the decision and output stages, the ram read data
//   and a full input register; in_stall rises once the input register is occupied behind a stalled result.
module strict_priority_nonpreemptive_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [spns_pkg::ID_W-1:0]       in_job_id,
  input  logic [spns_pkg::PRIO_W-1:0]     in_priority_level,
  input  logic [spns_pkg::LEN_W-1:0]      in_run_length,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_refused,
  output logic                            out_busy_res,
  output logic [spns_pkg::ID_W-1:0]       out_running_job,
  output logic [spns_pkg::PRIO_W-1:0]     out_running_level,
  output logic                            out_finished,
  output logic [spns_pkg::TIME_W-1:0]     out_began_at,
  output logic [spns_pkg::TIME_W-1:0]     out_tick_time,
  output logic                            out_closed,
  // configuration
  input  logic                            cfg_we,
  input  logic [spns_pkg::TIME_W-1:0]     cfg_wdata
);
  import spns_pkg::*;

  localparam int HW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int SW        = CW + 1;
  localparam int DEPTH_TOT = LEVELS * QUEUE_DEPTH;
  localparam int AW        = $clog2(DEPTH_TOT);
  localparam int RW        = ID_W + LEN_W;

  // result word as it travels through the decision and output stages
  typedef struct packed {
    logic              refused;
    logic              busy;
    logic [ID_W-1:0]   job;
    logic [PRIO_W-1:0] lvl;
    logic              fin;
    logic [TIME_W-1:0] began;
    logic [TIME_W-1:0] tick;
    logic              closed;
  } res_t;

  // pipeline control
  logic adv;
  logic a_vld_r, a_vld_nxt;
  logic b_vld_r, b_vld_nxt;
  logic o_vld_r, o_vld_nxt;
  logic b_pop_r, b_pop_nxt;

  // input register payload
  logic              a_kind_r;
  logic [ID_W-1:0]   a_id_r;
  logic [PRIO_W-1:0] a_prio_r;
  logic [LEN_W-1:0]  a_len_r;

  res_t b_res_r, b_res_nxt;
  res_t o_res_r, o_res_nxt;

  // scheduler state
  logic [TIME_W-1:0] cutoff_r, cutoff_nxt;
  logic [HW-1:0]     heads_r  [LEVELS];
  logic [HW-1:0]     heads_nxt[LEVELS];
  logic [CW-1:0]     counts_r [LEVELS];
  logic [CW-1:0]     counts_nxt[LEVELS];
  logic              act_vld_r, act_vld_nxt;
  logic [ID_W-1:0]   act_id_r, act_id_nxt;
  logic [LVL_W-1:0]  act_lvl_r, act_lvl_nxt;
  logic [LEN_W-1:0]  act_len_r, act_len_nxt;
  logic [LEN_W-1:0]  act_done_r, act_done_nxt;
  logic [TIME_W-1:0] act_start_r, act_start_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              halted_r, halted_nxt;

  // queue ram
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0]  rd_id;
  logic [LEN_W-1:0] rd_len;

  // level search
  logic [LEVELS-1:0] nonempty;
  pick_t             pick;

  // effective running job, with the pending ram read folded in
  logic              rd_fin;
  logic              eff_vld;
  logic [ID_W-1:0]   eff_id;
  logic [LEN_W-1:0]  eff_len;

  logic we_c, re_c;

  assign rd_id  = ram_rdata[RW-1 -: ID_W];
  assign rd_len = ram_rdata[LEN_W-1:0];

  // a job popped last step finishes at once when its length is at most one
  assign rd_fin  = (rd_len <= LEN_W'(1));
  assign eff_vld = act_vld_r && !(b_pop_r && rd_fin);
  assign eff_id  = b_pop_r ? rd_id  : act_id_r;
  assign eff_len = b_pop_r ? rd_len : act_len_r;

  // whole pipeline moves when the output register is free or being taken
  assign adv      = !o_vld_r || !out_stall;
  assign in_stall = a_vld_r && !adv;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (counts_r[i] != '0);
    end
  end

  spns_pick u_pick (
    .nonempty (nonempty),
    .pick     (pick)
  );

  spns_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH_TOT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we = we_c && adv;
  assign ram_re = re_c && adv;

  // decision stage
  always_comb begin
    logic [LVL_W-1:0]  arr_lvl;
    logic              prio_ok;
    logic [CW-1:0]     cnt;
    logic [SW-1:0]     slot_sum;
    logic [HW-1:0]     slot;
    logic [HW:0]       head_inc;
    logic [LEN_W-1:0]  done_n;
    logic              bump;

    arr_lvl  = LVL_W'(a_prio_r - PRIO_W'(1));
    prio_ok  = (a_prio_r >= PRIO_W'(1)) && (a_prio_r <= PRIO_W'(LEVELS));
    cnt      = counts_r[arr_lvl];
    slot_sum = SW'(heads_r[arr_lvl]) + SW'(cnt);
    if (slot_sum >= SW'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SW'(QUEUE_DEPTH);
    end
    slot     = slot_sum[HW-1:0];
    head_inc = (HW+1)'(heads_r[pick.lvl]) + (HW+1)'(1);
    if (head_inc >= (HW+1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
    done_n   = act_done_r + LEN_W'(1);
    bump     = 1'b0;

    heads_nxt     = heads_r;
    counts_nxt    = counts_r;
    act_vld_nxt   = eff_vld;
    act_id_nxt    = eff_id;
    act_len_nxt   = eff_len;
    act_lvl_nxt   = act_lvl_r;
    act_done_nxt  = act_done_r;
    act_start_nxt = act_start_r;
    now_nxt       = now_r;
    halted_nxt    = halted_r;
    b_pop_nxt     = 1'b0;
    we_c          = 1'b0;
    re_c          = 1'b0;
    ram_waddr     = AW'(arr_lvl) * AW'(QUEUE_DEPTH) + AW'(slot);
    ram_wdata     = {a_id_r, a_len_r};
    ram_raddr     = AW'(pick.lvl) * AW'(QUEUE_DEPTH) + AW'(heads_r[pick.lvl]);

    b_res_nxt        = '0;
    b_res_nxt.tick   = now_r;
    b_res_nxt.closed = halted_r;

    if (a_vld_r) begin
      if (a_kind_r == KIND_ARRIVAL) begin
        if (!halted_r && prio_ok && (cnt < CW'(QUEUE_DEPTH))) begin
          we_c                = 1'b1;
          counts_nxt[arr_lvl] = cnt + CW'(1);
        end else begin
          b_res_nxt.refused = 1'b1;
        end
      end else if (halted_r) begin
        b_res_nxt.closed = 1'b1;
      end else if (!eff_vld) begin
        if (now_r >= cutoff_r) begin
          // idle at or past the cutoff: close and drop everything waiting
          halted_nxt       = 1'b1;
          b_res_nxt.closed = 1'b1;
          for (int i = 0; i < LEVELS; i++) begin
            heads_nxt[i]  = '0;
            counts_nxt[i] = '0;
          end
        end else if (pick.found) begin
          // start the head of the best level; id and length arrive next cycle
          re_c                 = 1'b1;
          heads_nxt[pick.lvl]  = head_inc[HW-1:0];
          counts_nxt[pick.lvl] = counts_r[pick.lvl] - CW'(1);
          act_vld_nxt          = 1'b1;
          act_lvl_nxt          = pick.lvl;
          act_done_nxt         = LEN_W'(1);
          act_start_nxt        = now_r;
          b_pop_nxt            = 1'b1;
          b_res_nxt.busy       = 1'b1;
          b_res_nxt.lvl        = PRIO_W'(pick.lvl) + PRIO_W'(1);
          b_res_nxt.began      = now_r;
          bump                 = 1'b1;
        end else begin
          bump = 1'b1;
        end
      end else begin
        // running job counts one quantum
        act_done_nxt    = done_n;
        b_res_nxt.busy  = 1'b1;
        b_res_nxt.job   = eff_id;
        b_res_nxt.lvl   = PRIO_W'(act_lvl_r) + PRIO_W'(1);
        b_res_nxt.began = act_start_r;
        if (done_n >= eff_len) begin
          b_res_nxt.fin = 1'b1;
          act_vld_nxt   = 1'b0;
        end
        bump = 1'b1;
      end
      if (bump && (now_r != TIME_MAX)) begin
        now_nxt = now_r + TIME_W'(1);
      end
    end
  end

  // output stage picks up the ram read for a freshly started job
  always_comb begin
    o_res_nxt = b_res_r;
    if (b_pop_r) begin
      o_res_nxt.job = rd_id;
      o_res_nxt.fin = rd_fin;
    end
  end

  always_comb begin
    cutoff_nxt = cfg_we ? cfg_wdata : cutoff_r;
    o_vld_nxt  = adv ? b_vld_r : o_vld_r;
    b_vld_nxt  = adv ? a_vld_r : b_vld_r;
    if (in_valid && !in_stall) begin
      a_vld_nxt = 1'b1;
    end else begin
      a_vld_nxt = adv ? 1'b0 : a_vld_r;
    end
  end

  // control and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      o_vld_r     <= 1'b0;
      b_pop_r     <= 1'b0;
      cutoff_r    <= CUTOFF_RESET;
      act_vld_r   <= 1'b0;
      act_id_r    <= '0;
      act_lvl_r   <= '0;
      act_len_r   <= '0;
      act_done_r  <= '0;
      act_start_r <= '0;
      now_r       <= '0;
      halted_r    <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        heads_r[i]  <= '0;
        counts_r[i] <= '0;
      end
    end else begin
      a_vld_r  <= a_vld_nxt;
      b_vld_r  <= b_vld_nxt;
      o_vld_r  <= o_vld_nxt;
      cutoff_r <= cutoff_nxt;
      if (adv) begin
        b_pop_r     <= b_pop_nxt;
        act_vld_r   <= act_vld_nxt;
        act_id_r    <= act_id_nxt;
        act_lvl_r   <= act_lvl_nxt;
        act_len_r   <= act_len_nxt;
        act_done_r  <= act_done_nxt;
        act_start_r <= act_start_nxt;
        now_r       <= now_nxt;
        halted_r    <= halted_nxt;
        heads_r     <= heads_nxt;
        counts_r    <= counts_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_kind_r <= in_kind;
      a_id_r   <= in_job_id;
      a_prio_r <= in_priority_level;
      a_len_r  <= in_run_length;
    end
    if (adv) begin
      b_res_r <= b_res_nxt;
      o_res_r <= o_res_nxt;
    end
  end

  assign out_valid         = o_vld_r;
  assign out_refused       = o_res_r.refused;
  assign out_busy_res      = o_res_r.busy;
  assign out_running_job   = o_res_r.job;
  assign out_running_level = o_res_r.lvl;
  assign out_finished      = o_res_r.fin;
  assign out_began_at      = o_res_r.began;
  assign out_tick_time     = o_res_r.tick;
  assign out_closed        = o_res_r.closed;

endmodule

// File: rtl/spns_checker.sv
// port level checks for the scheduler and their binding
`timescale 1ns / 1ps
module spns_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_refused,
  input logic                        out_busy_res,
  input logic                        out_finished,
  input logic [spns_pkg::PRIO_W-1:0] out_running_level,
  input logic [spns_pkg::TIME_W-1:0] out_tick_time,
  input logic                        out_closed
);
  import spns_pkg::*;

  // no result word straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word visible right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tick_time))
    else $error("stalled result word changed");

  // a closed block runs nothing
  a_closed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_closed |-> !out_busy_res && !out_finished)
    else $error("job reported after closing");

  // completion only for a running job with a real level
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |->
      out_busy_res && (out_running_level != '0) &&
      (out_running_level <= PRIO_W'(LEVELS)))
    else $error("finish without a running job");

  // a refused arrival never reports a running job
  a_refused_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_refused |-> !out_busy_res && !out_finished)
    else $error("refused word carries a running job");

endmodule

bind strict_priority_nonpreemptive_scheduler_unit spns_checker u_spns_checker (.*);

// File: sim/strict_priority_nonpreemptive_scheduler_unit_tb.sv
// self-checking testbench for the four level strict priority non-preemptive scheduler
`timescale 1ns / 1ps
module strict_priority_nonpreemptive_scheduler_unit_tb;
  import spns_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic              drain;
  } sched_word_t;

  typedef struct packed {
    logic              refused;
    logic              busy;
    logic [ID_W-1:0]   job;
    logic [PRIO_W-1:0] lvl;
    logic              finished;
    logic [TIME_W-1:0] began;
    logic [TIME_W-1:0] tick;
    logic              closed;
  } sched_res_t;

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic                in_kind           = 1'b0;
  logic [ID_W-1:0]     in_job_id         = '0;
  logic [PRIO_W-1:0]   in_priority_level = '0;
  logic [LEN_W-1:0]    in_run_length     = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic                out_refused;
  logic                out_busy_res;
  logic [ID_W-1:0]     out_running_job;
  logic [PRIO_W-1:0]   out_running_level;
  logic                out_finished;
  logic [TIME_W-1:0]   out_began_at;
  logic [TIME_W-1:0]   out_tick_time;
  logic                out_closed;
  logic                cfg_we            = 1'b0;
  logic [TIME_W-1:0]   cfg_wdata         = '0;

  strict_priority_nonpreemptive_scheduler_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_job_id         (in_job_id),
    .in_priority_level (in_priority_level),
    .in_run_length     (in_run_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_refused       (out_refused),
    .out_busy_res      (out_busy_res),
    .out_running_job   (out_running_job),
    .out_running_level (out_running_level),
    .out_finished      (out_finished),
    .out_began_at      (out_began_at),
    .out_tick_time     (out_tick_time),
    .out_closed        (out_closed),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  // scheduler state as predicted
  bit [ID_W-1:0]   held_id  [LEVELS][QDEPTH];
  bit [LEN_W-1:0]  held_len [LEVELS][QDEPTH];
  int              head [LEVELS];
  int              fill [LEVELS];
  bit              run_on;
  bit [ID_W-1:0]   run_id;
  bit [LVL_W-1:0]  run_lvl;
  bit [LEN_W-1:0]  run_len;
  bit [LEN_W-1:0]  run_done;
  bit [TIME_W-1:0] run_start;
  bit [TIME_W-1:0] clock_now;
  bit [TIME_W-1:0] cutoff_cfg = CUTOFF_RESET;
  bit              shut;

  sched_word_t word_backlog[$];
  sched_res_t  due_results[$];
  sched_word_t on_wire;
  sched_res_t  got;
  sched_res_t  want;
  int          fail_count;
  int          quiet_cycles;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sched_res_t forecast_result(sched_word_t w);
    sched_res_t r;
    int         lvl;
    int         slot;
    bit         found;
    r      = '0;
    r.tick = clock_now;
    if (w.kind == KIND_ARRIVAL) begin
      r.closed = shut;
      lvl = int'(w.prio) - 1;
      if (shut || lvl < 0 || lvl >= LEVELS || fill[lvl] >= QDEPTH) begin
        r.refused = 1'b1;
      end else begin
        slot = (head[lvl] + fill[lvl]) % QDEPTH;
        held_id[lvl][slot]  = w.id;
        held_len[lvl][slot] = w.len;
        fill[lvl]++;
      end
      return r;
    end
    if (shut) begin
      r.closed = 1'b1;
      return r;
    end
    if (!run_on) begin
      // idle at or past the cutoff: drop everything waiting
      if (clock_now >= cutoff_cfg) begin
        shut = 1'b1;
        for (int k = 0; k < LEVELS; k++) begin
          head[k] = 0;
          fill[k] = 0;
        end
        r.closed = 1'b1;
        return r;
      end
      found = 1'b0;
      for (lvl = 0; lvl < LEVELS && !found; lvl++) begin
        if (fill[lvl] != 0) begin
          run_id    = held_id[lvl][head[lvl]];
          run_len   = held_len[lvl][head[lvl]];
          head[lvl] = (head[lvl] + 1) % QDEPTH;
          fill[lvl]--;
          run_lvl   = LVL_W'(lvl);
          run_done  = '0;
          run_start = clock_now;
          run_on    = 1'b1;
          found     = 1'b1;
        end
      end
    end
    if (run_on) begin
      r.busy   = 1'b1;
      r.job    = run_id;
      r.lvl    = PRIO_W'(run_lvl) + 3'd1;
      r.began  = run_start;
      run_done = run_done + 1'b1;
      if (run_done >= run_len) begin
        r.finished = 1'b1;
        run_on     = 1'b0;
      end
    end
    if (clock_now != TIME_MAX) clock_now++;
    return r;
  endfunction

  function automatic string show_result(sched_res_t r);
    return $sformatf({"ref=%0d busy=%0d job=%0d lvl=%0d fin=%0d ",
                      "began=%0d tick=%0d closed=%0d"},
                     r.refused, r.busy, r.job, r.lvl, r.finished, r.began, r.tick, r.closed);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("t=%0t %s", $time, msg);
  endtask

  task automatic push_arrival(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                              logic [LEN_W-1:0] len);
    sched_word_t w;
    w.kind  = KIND_ARRIVAL;
    w.id    = id;
    w.prio  = prio;
    w.len   = len;
    w.drain = 1'b0;
    word_backlog.push_back(w);
  endtask

  // tick words carry junk in the ignored fields
  task automatic push_tick();
    sched_word_t w;
    w.kind  = KIND_TICK;
    w.id    = ID_W'($urandom);
    w.prio  = PRIO_W'($urandom);
    w.len   = LEN_W'($urandom);
    w.drain = 1'b0;
    word_backlog.push_back(w);
  endtask

  task automatic add_random_phase(int n, int arrive_pct, bit lead_burst);
    int                i;
    int                burst;
    int                roll;
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    i = 0;
    while (i < n) begin
      if ((lead_burst && i == 0) || $urandom_range(0, 99) < 3) begin
        // burst into one level, enough to overflow it
        burst = $urandom_range(17, 20);
        prio  = PRIO_W'($urandom_range(1, LEVELS));
        repeat (burst) push_arrival(ID_W'($urandom), prio, LEN_W'($urandom_range(1, 4)));
        i += burst;
      end else if ($urandom_range(0, 99) < arrive_pct) begin
        if ($urandom_range(0, 99) < 6) prio = PRIO_W'($urandom_range(5, 8) % 8);
        else prio = PRIO_W'($urandom_range(1, LEVELS));
        roll = $urandom_range(0, 99);
        if (prio == 0 || prio > LEVELS) len = LEN_W'($urandom_range(0, 4095));
        else if (roll < 5) len = '0;
        else if (roll < 90) len = LEN_W'($urandom_range(1, 4));
        else len = LEN_W'($urandom_range(5, 40));
        push_arrival(ID_W'($urandom), prio, len);
        i++;
      end else begin
        push_tick();
        i++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (word_backlog.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [TIME_W-1:0] v);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    cutoff_cfg  = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: one word per handshake, payload held while stalled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) due_results.push_back(forecast_result(on_wire));
      if (!in_valid || !in_stall) begin
        if (word_backlog.size() != 0 && !(word_backlog[0].drain && due_results.size() != 0)
            && (calm || $urandom_range(0, 99) >= 29)) begin
          on_wire           = word_backlog.pop_front();
          in_valid          <= 1'b1;
          in_kind           <= on_wire.kind;
          in_job_id         <= on_wire.id;
          in_priority_level <= on_wire.prio;
          in_run_length     <= on_wire.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_refused, out_busy_res, out_running_job, out_running_level,
                out_finished, out_began_at, out_tick_time, out_closed};
        if (due_results.size() == 0) begin
          note_failure({"unexpected word: ", show_result(got)});
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            note_failure({"mismatch\n  want ", show_result(want),
                          "\n  got  ", show_result(got)});
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 29);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int lo;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset cutoff
    push_tick();
    push_arrival(8'h00, 3'd4, 12'd1);
    push_arrival(8'hFF, 3'd1, 12'd2);
    push_arrival(8'h5A, 3'd2, 12'd0);
    push_arrival(8'hA5, 3'd3, 12'd3);
    push_arrival(8'h3C, 3'd0, 12'hFFF);
    push_arrival(8'hC3, 3'd5, 12'h800);
    push_arrival(8'h69, 3'd6, 12'h7FF);
    push_arrival(8'h96, 3'd7, 12'd1);
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    // a higher level arriving mid-run must wait its turn
    push_arrival(8'h11, 3'd1, 12'd1);
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    wait_quiet();

    for (int p = 0; p < 7; p++) begin
      lo = int'(clock_now) + 140;
      if (p == 0) write_cutoff(TIME_MAX);
      else if (p == 1) write_cutoff(TIME_W'(lo));
      else write_cutoff(TIME_W'($urandom_range(lo, 65535)));
      calm = (p == 2);
      add_random_phase(60, $urandom_range(20, 45), p == 0);
      if (p % 2 == 1) word_backlog[word_backlog.size() / 2].drain = 1'b1;
      wait_quiet();
    end
    calm = 1'b0;

    // empty the queues, then run under a zero cutoff while a long job holds the block
    write_cutoff(TIME_MAX);
    while (run_on || fill[0] + fill[1] + fill[2] + fill[3] != 0) begin
      repeat (25) push_tick();
      wait_quiet();
    end
    push_arrival(ID_W'($urandom), 3'd1, 12'd60);
    push_tick();
    wait_quiet();
    write_cutoff('0);
    add_random_phase(120, 30, 1'b0);
    wait_quiet();
    while (!shut) begin
      repeat (20) push_tick();
      wait_quiet();
    end

    // closed: arrivals refused, time frozen
    add_random_phase(24, 50, 1'b0);
    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
